/* rtl/core/bitfile_header_stripper_top_assert.svh */
// assertion macros for the bit file header stripper
`ifndef BITFILE_HEADER_STRIPPER_TOP_ASSERT_SVH
`define BITFILE_HEADER_STRIPPER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BHS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bhs assertion failed");

// next-cycle implication, checked outside reset
`define BHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bhs assertion failed");

`endif

/* rtl/core/bhs_pkg.sv */
// types and constants for the bit file header stripper
`timescale 1ns / 1ps

package bhs_pkg;

   localparam logic [7:0]  TYPE_NAME      = 8'h62;
   localparam logic [7:0]  TYPE_END       = 8'h65;
   localparam logic [16:0] END_SKIP_N     = 17'd4;
   localparam logic [16:0] PRE_EXTRA      = 17'd2;
   localparam logic [15:0] CAPACITY_RESET = 16'd80;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_CHAR   = 2'd1;
   localparam logic [1:0] KIND_BYTE   = 2'd2;
   localparam logic [1:0] KIND_WORD   = 2'd3;

   localparam logic [1:0] STATUS_HEADER  = 2'd0;
   localparam logic [1:0] STATUS_PAYLOAD = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;
   localparam logic [1:0] STATUS_LONG    = 2'd3;

   localparam logic [1:0] WORD_LAST_POS = 2'd3;

   typedef enum logic [9:0] {
      PH_PRE_HI   = 10'b00_0000_0001,
      PH_PRE_LO   = 10'b00_0000_0010,
      PH_PRE_SKIP = 10'b00_0000_0100,
      PH_TYPE     = 10'b00_0000_1000,
      PH_LEN_HI   = 10'b00_0001_0000,
      PH_LEN_LO   = 10'b00_0010_0000,
      PH_BODY     = 10'b00_0100_0000,
      PH_END_SKIP = 10'b00_1000_0000,
      PH_PAYLOAD  = 10'b01_0000_0000,
      PH_HALT     = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0]  item_kind;
      logic [31:0] char_or_word;
      logic [1:0]  parse_status;
      logic        file_end;
      logic [31:0] payload_bytes;
      logic [31:0] byte_index;
   } result_type;

endpackage

/* rtl/core/bhs_ifs.sv */
// stream and register write interfaces of the bit file header stripper
`timescale 1ns / 1ps

interface bhs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;
   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface bhs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  item_kind;
   logic [31:0] char_or_word;
   logic [1:0]  parse_status;
   logic        file_end;
   logic [31:0] payload_bytes;
   logic [31:0] byte_index;
   modport source (output valid, output item_kind, output char_or_word,
                   output parse_status, output file_end, output payload_bytes,
                   output byte_index, input ready);
   modport sink (input valid, input item_kind, input char_or_word,
                 input parse_status, input file_end, input payload_bytes,
                 input byte_index, output ready);
endinterface

interface bhs_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] ident_capacity;
   modport source (output valid, output ident_capacity, input ready);
   modport sink (input valid, input ident_capacity, output ready);
endinterface

/* rtl/core/bhs_parser.sv */
// header parse state and per-byte step logic
`timescale 1ns / 1ps
`include "bitfile_header_stripper_top_assert.svh"

module bhs_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         byte_in,
   input  logic               last_byte,
   input  logic [15:0]        ident_capacity,
   output bhs_pkg::result_type result
);
   import bhs_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [16:0] skip_ff, skip_in;
   logic [15:0] len_ff, len_in;
   logic        class_ff, class_in;
   logic [23:0] shift_ff, shift_in;
   logic [1:0]  wpos_ff, wpos_in;
   logic [31:0] pay_ff, pay_in;
   logic [31:0] pos_ff, pos_in;
   logic [1:0]  err_ff, err_in;

   logic [1:0]  kind;
   logic [31:0] data;
   logic [1:0]  status;
   logic [16:0] skip_dec;

   assign skip_dec = skip_ff - 17'd1;

   always_comb begin
      phase_in = phase_ff;
      skip_in  = skip_ff;
      len_in   = len_ff;
      class_in = class_ff;
      shift_in = shift_ff;
      wpos_in  = wpos_ff;
      pay_in   = pay_ff;
      err_in   = err_ff;
      kind     = KIND_HEADER;
      data     = 32'd0;
      case (phase_ff)
         PH_PRE_HI: begin
            len_in   = {byte_in, 8'h00};
            phase_in = PH_PRE_LO;
         end
         PH_PRE_LO: begin
            len_in   = {len_ff[15:8], byte_in};
            skip_in  = {1'b0, len_ff[15:8], byte_in} + PRE_EXTRA;
            phase_in = PH_PRE_SKIP;
         end
         PH_PRE_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 17'd0) begin
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if (byte_in == TYPE_END) begin
               skip_in  = END_SKIP_N;
               phase_in = PH_END_SKIP;
            end else begin
               class_in = (byte_in == TYPE_NAME);
               phase_in = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            len_in   = {byte_in, 8'h00};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in = {len_ff[15:8], byte_in};
            if (class_ff && ({len_ff[15:8], byte_in} >= ident_capacity)) begin
               err_in   = STATUS_LONG;
               phase_in = PH_HALT;
            end else if ({len_ff[15:8], byte_in} == 16'd0) begin
               phase_in = PH_TYPE;
            end else begin
               skip_in  = {1'b0, len_ff[15:8], byte_in};
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (class_ff) begin
               kind = KIND_CHAR;
               data = {24'd0, byte_in};
            end
            skip_in = skip_dec;
            if (skip_dec == 17'd0) begin
               phase_in = PH_TYPE;
            end
         end
         PH_END_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 17'd0) begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            pay_in = pay_ff + 32'd1;
            if (wpos_ff == WORD_LAST_POS) begin
               kind     = KIND_WORD;
               data     = {shift_ff, byte_in};
               shift_in = 24'd0;
               wpos_in  = 2'd0;
            end else begin
               kind     = KIND_BYTE;
               data     = {24'd0, byte_in};
               shift_in = {shift_ff[15:0], byte_in};
               wpos_in  = wpos_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase

      // end of file short of the payload
      if (last_byte && (err_in == STATUS_HEADER) && (phase_in != PH_PAYLOAD)) begin
         err_in = STATUS_SHORT;
      end

      if (err_in != STATUS_HEADER) begin
         status = err_in;
      end else if (phase_in == PH_PAYLOAD) begin
         status = STATUS_PAYLOAD;
      end else begin
         status = STATUS_HEADER;
      end

      pos_in = pos_ff + 32'd1;

      // file done: start over for the next file
      if (last_byte) begin
         phase_in = PH_PRE_HI;
         skip_in  = 17'd0;
         len_in   = 16'd0;
         class_in = 1'b0;
         shift_in = 24'd0;
         wpos_in  = 2'd0;
         pay_in   = 32'd0;
         pos_in   = 32'd0;
         err_in   = STATUS_HEADER;
      end
   end

   always_comb begin
      result.item_kind     = kind;
      result.char_or_word  = data;
      result.parse_status  = status;
      result.file_end      = last_byte;
      result.payload_bytes = (phase_ff == PH_PAYLOAD) ? pay_ff + 32'd1 : pay_ff;
      result.byte_index    = pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PRE_HI;
         skip_ff  <= 17'd0;
         len_ff   <= 16'd0;
         class_ff <= 1'b0;
         shift_ff <= 24'd0;
         wpos_ff  <= 2'd0;
         pay_ff   <= 32'd0;
         pos_ff   <= 32'd0;
         err_ff   <= STATUS_HEADER;
      end else if (step) begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         len_ff   <= len_in;
         class_ff <= class_in;
         shift_ff <= shift_in;
         wpos_ff  <= wpos_in;
         pay_ff   <= pay_in;
         pos_ff   <= pos_in;
         err_ff   <= err_in;
      end
   end

   `BHS_ASSERT_NEXT(a_last_restarts, clock, reset, step && last_byte, phase_ff == PH_PRE_HI && pos_ff == 32'd0 && pay_ff == 32'd0)
   `BHS_ASSERT_NEXT(a_index_counts, clock, reset, step && !last_byte, pos_ff == $past(pos_ff) + 32'd1)
   `BHS_ASSERT_NOW(a_word_in_payload, clock, reset, step && kind == KIND_WORD, status == STATUS_PAYLOAD)
   `BHS_ASSERT_NOW(a_char_in_header, clock, reset, step && kind == KIND_CHAR, status == STATUS_HEADER || status == STATUS_SHORT)

endmodule

/* rtl/core/bitfile_header_stripper_top.sv */
// bit file header stripper: input stage, parser and result register
// an accepted byte waits in the input stage; once the result register is free the parser
//   steps on it, and its result is registered in the result register and offered on rsp_ch
// throughput: one byte per cycle; while a result waits the input stage takes one more
//   byte, then stalls until the result transfers
// reset clears parse state, counters and both stages; ident_capacity returns to 80
`timescale 1ns / 1ps

module bitfile_header_stripper_top (
   input logic       clock,
   input logic       reset,
   bhs_req_if.sink   req_ch,
   bhs_rsp_if.source rsp_ch,
   bhs_csr_if.sink   csr_ch
);
   import bhs_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_last_ff, in_last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;
   logic [15:0] cap_ff, cap_in;

   logic        out_free;
   logic        step;
   logic        req_take;
   result_type  step_result;

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign step          = in_valid_ff && out_free;
   assign req_ch.ready  = !in_valid_ff || out_free;
   assign req_take      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;

   bhs_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .byte_in        (in_byte_ff),
      .last_byte      (in_last_ff),
      .ident_capacity (cap_ff),
      .result         (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cap_in       = cap_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.byte_in;
         in_last_in  = req_ch.last_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_ch.valid) begin
         cap_in = csr_ch.ident_capacity;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAPACITY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.item_kind     = rsp_data_ff.item_kind;
   assign rsp_ch.char_or_word  = rsp_data_ff.char_or_word;
   assign rsp_ch.parse_status  = rsp_data_ff.parse_status;
   assign rsp_ch.file_end      = rsp_data_ff.file_end;
   assign rsp_ch.payload_bytes = rsp_data_ff.payload_bytes;
   assign rsp_ch.byte_index    = rsp_data_ff.byte_index;

endmodule
